### rtl/core/crsf_pkg.sv
`timescale 1ns / 1ps

package crsf_pkg;

  localparam int unsigned MAX_FRAME_DEF = 64;
  localparam int unsigned MIN_TOTAL     = 4;
  localparam int unsigned LEN_OVERHEAD  = 2;
  localparam logic [7:0]  CRC_POLY      = 8'hD5;
  localparam int unsigned CRC_STEPS     = 8;

  typedef enum logic [1:0] {
    KIND_FRAME_BYTE = 2'd0,
    KIND_GOOD_HELD  = 2'd1,
    KIND_CRC_ERROR  = 2'd2,
    KIND_LEN_DROP   = 2'd3
  } kind_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CRC,
    ST_STATUS,
    ST_REP_RD,
    ST_REP_OUT
  } state_e;

  typedef struct packed {
    logic       clear;
    logic       load;
    logic [7:0] data;
  } crc_cmd_t;

  typedef struct packed {
    logic       busy;
    logic       done;
    logic [7:0] crc;
  } crc_sts_t;

endpackage

### rtl/core/crsf_crc_unit.sv
`timescale 1ns / 1ps

module crsf_crc_unit
  import crsf_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  crc_cmd_t cmd_i,
  output crc_sts_t sts_o
);

  localparam int unsigned CW = $clog2(CRC_STEPS);

  logic [7:0]    crc_q, crc_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic          busy_q, busy_d;
  logic          last_step;

  assign last_step = (cnt_q == CW'(CRC_STEPS - 1));

  always_comb begin
    crc_d  = crc_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    if (cmd_i.clear) begin
      crc_d  = '0;
      busy_d = 1'b0;
    end else if (cmd_i.load) begin
      // fold the byte in, then shift it through bit by bit while busy
      crc_d  = crc_q ^ cmd_i.data;
      cnt_d  = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      crc_d = crc_q[7] ? ({crc_q[6:0], 1'b0} ^ CRC_POLY) : {crc_q[6:0], 1'b0};
      cnt_d = CW'(cnt_q + CW'(1));
      if (last_step) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      crc_q  <= '0;
      cnt_q  <= '0;
      busy_q <= 1'b0;
    end else begin
      crc_q  <= crc_d;
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
    end
  end

  assign sts_o.busy = busy_q;
  assign sts_o.done = busy_q && last_step;
  assign sts_o.crc  = crc_q;

endmodule

### rtl/core/crsf_frame_store.sv
`timescale 1ns / 1ps

module crsf_frame_store #(
  parameter int unsigned DEPTH = 64,
  parameter int unsigned IW    = $clog2(DEPTH)
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [IW-1:0] waddr_i,
  input  logic [7:0]    wdata_i,
  input  logic          re_i,
  input  logic [IW-1:0] raddr_i,
  output logic [7:0]    rdata_o
);

  logic [7:0] mem_q [DEPTH];
  logic [7:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/core/crsf_serial_frame_parser_top.sv
`timescale 1ns / 1ps

// Serial frame parser: takes one received byte per transaction and assembles
// address, length, type/payload and CRC bytes into a frame in a local store.
// Address, length and final CRC bytes are taken without a CRC wait; every
// type/payload byte stalls input until the bit-serial CRC-8 unit (poly 0xD5)
// that shifts one bit per cycle has folded it in. A status result (good but
// held, CRC error, length drop) holds input until it is taken. A forwarded frame
// is replayed from the store, each byte a registered memory read, then output,
// and input stalls until the last byte is taken. The three 32-bit counters on
// the result ports already include the frame that caused the result.
module crsf_serial_frame_parser_top
  import crsf_pkg::*;
#(
  parameter int unsigned MAX_FRAME = MAX_FRAME_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  rx_byte_i,
  input  logic        link_up_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  kind_o,
  output logic [7:0]  data_byte_o,
  output logic        last_o,
  output logic [31:0] good_frames_o,
  output logic [31:0] crc_errors_o,
  output logic [31:0] drop_count_o
);

  localparam int unsigned IW = $clog2(MAX_FRAME);
  localparam int unsigned TW = $clog2(MAX_FRAME + 1);

  state_e        state_q, state_d;
  logic [IW-1:0] pos_q;
  logic [TW-1:0] total_q;
  logic [31:0]   good_q, err_q, drop_q;
  kind_e         kind_q;
  logic [IW-1:0] rep_idx_q, rep_end_q;

  logic       in_acc, is_addr, is_len, is_final, len_bad, crc_ok;
  logic [8:0] len_sum;
  logic       mem_we, mem_re;
  logic [7:0] mem_rdata;
  crc_cmd_t   crc_cmd;
  crc_sts_t   crc_sts;

  assign in_acc   = in_valid_i && (state_q == ST_IDLE);
  assign is_addr  = (pos_q == '0);
  assign is_len   = (pos_q == IW'(1));
  assign len_sum  = {1'b0, rx_byte_i} + 9'(LEN_OVERHEAD);
  assign len_bad  = (len_sum < 9'(MIN_TOTAL)) || (len_sum > 9'(MAX_FRAME));
  assign is_final = !is_addr && !is_len && ((TW'(pos_q) + TW'(1)) == total_q);
  assign crc_ok   = (crc_sts.crc == rx_byte_i);

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          if (is_len && len_bad) begin
            state_d = ST_STATUS;
          end else if (is_addr || is_len) begin
            state_d = ST_IDLE;
          end else if (!is_final) begin
            state_d = ST_CRC;
          end else if (!crc_ok || !link_up_i) begin
            state_d = ST_STATUS;
          end else begin
            state_d = ST_REP_RD;
          end
        end
      end
      ST_CRC: begin
        if (crc_sts.done) begin
          state_d = ST_IDLE;
        end
      end
      ST_STATUS: begin
        if (!out_stall_i) begin
          state_d = ST_IDLE;
        end
      end
      ST_REP_RD: begin
        state_d = ST_REP_OUT;
      end
      ST_REP_OUT: begin
        if (!out_stall_i) begin
          state_d = (rep_idx_q == rep_end_q) ? ST_IDLE : ST_REP_RD;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    in_stall_o   = (state_q != ST_IDLE);
    mem_we       = in_acc;
    mem_re       = (state_q == ST_REP_RD);
    crc_cmd.load = in_acc && !is_addr && !is_len && !is_final;
    crc_cmd.clear = in_acc && !crc_cmd.load;
    crc_cmd.data = rx_byte_i;
    out_valid_o  = (state_q == ST_STATUS) || (state_q == ST_REP_OUT);
    last_o       = (state_q == ST_STATUS) || (rep_idx_q == rep_end_q);
    kind_o       = (state_q == ST_REP_OUT) ? KIND_FRAME_BYTE : kind_q;
    data_byte_o  = (state_q == ST_REP_OUT) ? mem_rdata : 8'd0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      pos_q     <= '0;
      total_q   <= '0;
      good_q    <= '0;
      err_q     <= '0;
      drop_q    <= '0;
      kind_q    <= KIND_LEN_DROP;
      rep_idx_q <= '0;
      rep_end_q <= '0;
    end else begin
      state_q <= state_d;
      if (in_acc) begin
        if (is_addr) begin
          pos_q <= IW'(1);
        end else if (is_len) begin
          if (len_bad) begin
            pos_q  <= '0;
            drop_q <= drop_q + 32'd1;
            kind_q <= KIND_LEN_DROP;
          end else begin
            pos_q   <= IW'(2);
            total_q <= len_sum[TW-1:0];
          end
        end else if (!is_final) begin
          pos_q <= IW'(pos_q + IW'(1));
        end else begin
          // final byte: check CRC and restart at the address byte
          pos_q     <= '0;
          rep_idx_q <= '0;
          rep_end_q <= IW'(total_q - TW'(1));
          if (!crc_ok) begin
            err_q  <= err_q + 32'd1;
            kind_q <= KIND_CRC_ERROR;
          end else begin
            good_q <= good_q + 32'd1;
            kind_q <= KIND_GOOD_HELD;
          end
        end
      end
      if ((state_q == ST_REP_OUT) && !out_stall_i && (rep_idx_q != rep_end_q)) begin
        rep_idx_q <= IW'(rep_idx_q + IW'(1));
      end
    end
  end

  assign good_frames_o = good_q;
  assign crc_errors_o  = err_q;
  assign drop_count_o  = drop_q;

  crsf_crc_unit u_crc (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (crc_cmd),
    .sts_o  (crc_sts)
  );

  crsf_frame_store #(
    .DEPTH (MAX_FRAME),
    .IW    (IW)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (pos_q),
    .wdata_i (rx_byte_i),
    .re_i    (mem_re),
    .raddr_i (rep_idx_q),
    .rdata_o (mem_rdata)
  );

`ifndef SYNTHESIS
  a_no_accept_while_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> in_stall_o)
    else $error("input accepted while a result is pending");

  a_crc_busy_in_crc_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CRC) |-> crc_sts.busy)
    else $error("sequencer waits on an idle CRC unit");

  a_replay_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_REP_OUT) |-> (rep_idx_q <= rep_end_q))
    else $error("replay index past end of frame");

  a_status_data_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (kind_o != KIND_FRAME_BYTE)) |-> (data_byte_o == 8'd0) && last_o)
    else $error("status result with data or without last");
`endif

endmodule
